// ----- design/msa_pkg.sv -----
// Package for the multichannel sample averager.
// Holds field widths, configuration register codes and the structs shared by the
// datapath, the memory and the output queue. It depends on nothing else.
package msa_pkg;

  localparam int CH_W       = 5;
  localparam int SMP_W      = 12;
  localparam int SUM_W      = 16;
  localparam int CNT_W      = 5;
  localparam int LEN_W      = 5;
  localparam int SHIFT_W    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [LEN_W-1:0]   MAX_BLOCK       = 5'd16;
  localparam logic [LEN_W-1:0]   RST_BLOCK_LEN   = 5'd15;
  localparam logic [SHIFT_W-1:0] RST_AVG_SHIFT   = 3'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_LENGTH  = 2'd0,
    REG_AVERAGE_SHIFT = 2'd1
  } cfg_reg_t;

  // One channel's stored state.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
  } msa_ent_t;

  // Write-back request from the update stage to the state memory.
  typedef struct packed {
    logic            en;
    logic [CH_W-1:0] ch;
    msa_ent_t        ent;
  } msa_wr_t;

  // One finished result.
  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [SUM_W-1:0] average;
  } msa_res_t;

endpackage

// ----- design/multichannel_sample_averager_top.sv -----
// Top level of the multichannel sample averager.
// Depends on msa_pkg, msa_core (with msa_mem) and msa_out_fifo.
//
// The averager takes one converter transfer per clock while in_stall is low:
// a channel number and a 12-bit sample. Channels at or above NUM_CHANNELS are
// dropped silently. For a valid channel the sample is added to that channel's
// 16-bit running sum and its count is incremented; once the count reaches the
// block length (register 0, values 0 and above 16 act as 1 and 16) the block
// emits one result, the channel number and the sum shifted right by register
// 1, and clears that channel. Throughput is one input transfer per cycle
// while in_stall is low: the channel state sits in a single-port-read,
// single-port-write memory with registered read data, and a back-to-back
// update of the same channel is served by forwarding the value being written
// back, so no bubble is ever inserted. A result is formed in the update stage
// and waits in a three-entry queue whose head drives the output; in_stall
// rises only when that queue together with the item in the update stage
// could overflow, so in_stall is a registered function of the block's own
// state and never combinationally follows out_stall. No clearing pass is
// needed after reset: per-channel valid bits make untouched channels read as
// zero. Configuration writes are always accepted (cfg_ready is tied high) and
// must only be issued while the block is idle.
module multichannel_sample_averager_top
  import msa_pkg::*;
#(
  parameter int NUM_CHANNELS = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CH_W-1:0]       in_channel,
  input  logic [SMP_W-1:0]      in_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CH_W-1:0]       out_channel,
  output logic [SUM_W-1:0]      out_average,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [LEN_W-1:0]   block_length_r;
  logic [SHIFT_W-1:0] average_shift_r;
  logic               in_acc;
  logic               busy;
  logic               res_valid;
  msa_res_t           res;
  msa_res_t           head;
  logic [1:0]         q_count;

  // Configuration registers; unknown indexes are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_length_r  <= RST_BLOCK_LEN;
      average_shift_r <= RST_AVG_SHIFT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BLOCK_LENGTH:  block_length_r  <= cfg_data[LEN_W-1:0];
        REG_AVERAGE_SHIFT: average_shift_r <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // The item accepted now pushes its result from the update stage; by then the
  // queue holds at most its current contents plus the update-stage result.
  assign in_stall = ((3'(q_count) + 3'(busy)) > 3'd2);
  assign in_acc   = in_valid && !in_stall;

  msa_core #(.NUM_CHANNELS(NUM_CHANNELS)) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (in_acc),
    .ch            (in_channel),
    .sample        (in_sample),
    .block_length  (block_length_r),
    .average_shift (average_shift_r),
    .busy          (busy),
    .res_valid     (res_valid),
    .res           (res)
  );

  msa_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .pop        (!out_stall),
    .head_valid (out_valid),
    .head       (head),
    .count      (q_count)
  );

  assign out_channel = head.channel;
  assign out_average = head.average;

endmodule

// ----- design/msa_mem.sv -----
// Per-channel state memory of the averager: running sum and sample count.
// One synchronous write port, one read port with registered data. Uses msa_pkg.
module msa_mem
  import msa_pkg::*;
#(
  parameter int NUM_CHANNELS = 14
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            rd_en,
  input  logic [CH_W-1:0] rd_ch,
  output msa_ent_t        rd_ent,
  input  msa_wr_t         wr
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  msa_ent_t                mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld_r;
  msa_ent_t                rd_data_r;
  logic                    rd_vld_r;

  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;

  assign rd_idx = rd_ch[IDX_W-1:0];
  assign wr_idx = wr.ch[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_idx] <= wr.ent;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_idx];
      end
    end
  end

  assign rd_ent = rd_vld_r ? rd_data_r : '0;

endmodule

// ----- design/msa_core.sv -----
// Read-modify-write pipeline of the averager: read issue, update stage,
// write-back forwarding and the emit decision. Uses msa_pkg and msa_mem.
module msa_core
  import msa_pkg::*;
#(
  parameter int NUM_CHANNELS = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  logic [CH_W-1:0]    ch,
  input  logic [SMP_W-1:0]   sample,
  input  logic [LEN_W-1:0]   block_length,
  input  logic [SHIFT_W-1:0] average_shift,
  output logic               busy,
  output logic               res_valid,
  output msa_res_t           res
);

  localparam logic [CH_W:0] NUM_CH_V = (CH_W+1)'(NUM_CHANNELS);

  logic             in_range;
  logic             s1_valid_r;
  logic [CH_W-1:0]  s1_ch_r;
  logic [SMP_W-1:0] s1_sample_r;
  logic             wb_valid_r;
  logic [CH_W-1:0]  wb_ch_r;
  msa_ent_t         wb_ent_r;
  msa_ent_t         rd_ent;
  msa_ent_t         cur;
  logic             fwd_hit;
  logic [SUM_W-1:0] sum_new;
  logic [CNT_W-1:0] cnt_new;
  logic [LEN_W-1:0] eff_len;
  logic             emit;
  msa_wr_t          wr;

  assign in_range = ({1'b0, ch} < NUM_CH_V);

  msa_mem #(.NUM_CHANNELS(NUM_CHANNELS)) u_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (acc && in_range),
    .rd_ch  (ch),
    .rd_ent (rd_ent),
    .wr     (wr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      wb_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= acc && in_range;
      wb_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_ch_r     <= ch;
      s1_sample_r <= sample;
    end
    if (s1_valid_r) begin
      wb_ch_r  <= s1_ch_r;
      wb_ent_r <= wr.ent;
    end
  end

  // The read for this item was issued while the previous item was writing;
  // if both hit the same channel, take the value just written.
  assign fwd_hit = wb_valid_r && (wb_ch_r == s1_ch_r);
  assign cur     = fwd_hit ? wb_ent_r : rd_ent;

  always_comb begin
    priority if (block_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (block_length > MAX_BLOCK) begin
      eff_len = MAX_BLOCK;
    end else begin
      eff_len = block_length;
    end
  end

  assign sum_new = cur.sum + SUM_W'(s1_sample_r);
  assign cnt_new = cur.cnt + CNT_W'(1);
  assign emit    = (cnt_new >= eff_len);

  always_comb begin
    wr.en      = s1_valid_r;
    wr.ch      = s1_ch_r;
    wr.ent.sum = emit ? '0 : sum_new;
    wr.ent.cnt = emit ? '0 : cnt_new;
  end

  assign busy        = s1_valid_r;
  assign res_valid   = s1_valid_r && emit;
  assign res.channel = s1_ch_r;
  assign res.average = sum_new >> average_shift;

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> ({1'b0, wr.ch} < NUM_CH_V))
    else $error("write to a channel outside the configured range");

  a_cnt_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (wr.ent.cnt < MAX_BLOCK))
    else $error("stored sample count reached the block limit");

  a_fwd_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (fwd_hit |-> (cur.cnt == '0 && cur.sum == '0)))
    else $error("forwarded state not cleared after emit");

endmodule

// ----- design/msa_out_fifo.sv -----
// Three-entry result queue of the averager; its head drives the output port.
// Uses msa_pkg.
module msa_out_fifo
  import msa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  msa_res_t push_data,
  input  logic     pop,
  output logic     head_valid,
  output msa_res_t head,
  output logic [1:0] count
);

  localparam logic [1:0] DEPTH = 2'd3;

  msa_res_t   ent [3];
  logic [1:0] wr_ptr_r;
  logic [1:0] rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] wr_ptr_nxt;
  logic [1:0] rd_ptr_nxt;
  logic [1:0] count_nxt;
  logic       do_pop;

  assign do_pop = pop && (count_r != 2'd0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == DEPTH - 2'd1) ? 2'd0 : wr_ptr_r + 2'd1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == DEPTH - 2'd1) ? 2'd0 : rd_ptr_r + 2'd1;
    end
    unique case ({push, do_pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr_r] <= push_data;
    end
  end

  assign head_valid = (count_r != 2'd0);
  assign head       = ent[rd_ptr_r];
  assign count      = count_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != DEPTH))
    else $error("result queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH)
    else $error("result queue count out of range");

  a_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (head_valid && !pop) |=> (head_valid && $stable(rd_ptr_r)))
    else $error("queue head moved without a pop");

endmodule
